### rtl/ltmc_pkg.sv
// shared types, codes and rule tables for the line tracking move controller
`timescale 1ns / 1ps
`default_nettype none

package ltmc_pkg;

  // motor command codes
  localparam logic [1:0] MOT_OFF = 2'd0;
  localparam logic [1:0] MOT_FWD = 2'd1;
  localparam logic [1:0] MOT_REV = 2'd2;

  // direction codes
  localparam logic [2:0] DIR_FWD   = 3'd1;
  localparam logic [2:0] DIR_BACK  = 3'd2;
  localparam logic [2:0] DIR_LEFT  = 3'd3;
  localparam logic [2:0] DIR_RIGHT = 3'd4;

  // configuration register indexes
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT_ARG = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_ARG  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BLANK_MS  = 2'd3;

  // register reset values
  localparam logic [2:0]        RST_DIRECTION = DIR_FWD;
  localparam logic signed [8:0] RST_COUNT_ARG = 9'sd1;
  localparam logic [15:0]       RST_TIME_ARG  = 16'd10;
  localparam logic [15:0]       RST_BLANK_MS  = 16'd800;

  // pulse length used in time mode
  localparam logic [15:0] TIME_MODE_STEP_MS = 16'd5;

  // marker sensor bit positions (sensor 5 front/back, sensor 8 left/right)
  localparam int MARK_BIT_FB = 4;
  localparam int MARK_BIT_LR = 7;

  // steering rules; all are checked and every matching rule gives a pulse, in index order
  localparam int NUM_RULES = 9;

  localparam logic [11:0] FB_WHITE [0:NUM_RULES-1] = '{
    12'h240, 12'h300, 12'h840, 12'h900, 12'h440, 12'h500, 12'h280, 12'h880, 12'h480};
  localparam logic [11:0] FB_BLACK [0:NUM_RULES-1] = '{
    12'h900, 12'h840, 12'h300, 12'h240, 12'h100, 12'h040, 12'h800, 12'h200, 12'h000};
  localparam logic [1:0] FB_A [0:NUM_RULES-1] = '{
    MOT_FWD, MOT_REV, MOT_FWD, MOT_REV, MOT_FWD, MOT_REV, MOT_OFF, MOT_OFF, MOT_OFF};
  localparam logic [1:0] FB_B [0:NUM_RULES-1] = '{
    MOT_FWD, MOT_FWD, MOT_REV, MOT_REV, MOT_OFF, MOT_OFF, MOT_FWD, MOT_REV, MOT_OFF};

  localparam logic [11:0] LR_WHITE [0:NUM_RULES-1] = '{
    12'h024, 12'h00C, 12'h021, 12'h009, 12'h00A, 12'h022, 12'h011, 12'h014, 12'h012};
  localparam logic [11:0] LR_BLACK [0:NUM_RULES-1] = '{
    12'h009, 12'h021, 12'h00C, 12'h024, 12'h020, 12'h008, 12'h004, 12'h001, 12'h000};
  localparam logic [1:0] LR_A [0:NUM_RULES-1] = '{
    MOT_FWD, MOT_FWD, MOT_REV, MOT_REV, MOT_OFF, MOT_OFF, MOT_REV, MOT_FWD, MOT_OFF};
  localparam logic [1:0] LR_B [0:NUM_RULES-1] = '{
    MOT_FWD, MOT_REV, MOT_FWD, MOT_REV, MOT_REV, MOT_FWD, MOT_OFF, MOT_OFF, MOT_OFF};

  // input beat
  typedef struct packed {
    logic        start_req;
    logic [11:0] sensors;
  } in_beat_t;

  // output beat
  typedef struct packed {
    logic [1:0]  side_a_cmd;
    logic [1:0]  side_b_cmd;
    logic [1:0]  drive_cmd;
    logic [15:0] pulse_ms;
    logic        done_res;
    logic        last;
  } out_beat_t;

  // configuration registers
  typedef struct packed {
    logic [2:0]        direction;
    logic signed [8:0] count_arg;
    logic [15:0]       time_arg;
    logic [15:0]       blank_ms;
  } cfg_t;

  // matched item, ready for the state update
  typedef struct packed {
    logic                 start;
    logic                 dir_ok;
    logic                 fb;
    logic [1:0]           drv;
    logic                 marker;
    logic [NUM_RULES-1:0] mask;
    logic [19:0]          inc;
    logic [15:0]          step;
    logic [15:0]          limit;
    logic [15:0]          blank;
    logic [7:0]           target;
  } item_t;

  // pulse job handed to the serializer
  typedef struct packed {
    logic [NUM_RULES-1:0] mask;
    logic                 fb;
    logic [1:0]           drv;
    logic [15:0]          step;
    logic                 done;
  } job_t;

endpackage

`default_nettype wire

### rtl/ltmc_match.sv
// input register and rule matching stage
`timescale 1ns / 1ps
`default_nettype none

module ltmc_match (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  ltmc_pkg::in_beat_t in_data,
  input  ltmc_pkg::cfg_t   cfg,
  output logic             item_valid,
  output ltmc_pkg::item_t  item,
  input  logic             item_take
);
  import ltmc_pkg::*;

  logic        s1_valid;
  in_beat_t    s1;
  logic        s1_adv;
  item_t       item_next;
  logic        fb;
  logic        time_mode;
  logic        cnt_zero;
  logic [3:0]  hits;
  logic [15:0] step;
  logic [11:0] wm;
  logic [11:0] bm;

  // stage handshake
  assign s1_adv   = !item_valid || item_take;
  assign in_stall = s1_valid && !s1_adv;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1 <= in_data;
    end
  end

  // direction and mode decode
  assign fb        = (cfg.direction == DIR_FWD) || (cfg.direction == DIR_BACK);
  assign time_mode = cfg.count_arg[8];
  assign cnt_zero  = (cfg.count_arg == 9'sd0);
  assign step      = time_mode ? TIME_MODE_STEP_MS : cfg.time_arg;

  // rule matching and pulse time
  always_comb begin
    wm = 12'd0;
    bm = 12'd0;
    item_next.mask = '0;
    for (int i = 0; i < NUM_RULES; i++) begin
      wm = fb ? FB_WHITE[i] : LR_WHITE[i];
      bm = fb ? FB_BLACK[i] : LR_BLACK[i];
      item_next.mask[i] = ((s1.sensors & wm) == wm) && ((s1.sensors & bm) == 12'd0);
    end
    hits = 4'($countones(item_next.mask));
    if (hits == 4'd0) begin
      hits = 4'd1;
    end
    item_next.start  = s1.start_req;
    item_next.dir_ok = fb || (cfg.direction == DIR_LEFT) || (cfg.direction == DIR_RIGHT);
    item_next.fb     = fb;
    item_next.drv    = ((cfg.direction == DIR_FWD) || (cfg.direction == DIR_LEFT)) ?
                       MOT_FWD : MOT_REV;
    item_next.marker = fb ? s1.sensors[MARK_BIT_FB] : s1.sensors[MARK_BIT_LR];
    item_next.inc    = 20'(hits) * 20'(step);
    item_next.step   = step;
    item_next.limit  = time_mode ? cfg.time_arg : 16'd0;
    item_next.blank  = cnt_zero ? 16'd0 : cfg.blank_ms;
    item_next.target = (time_mode || cnt_zero) ? 8'd1 : cfg.count_arg[7:0];
  end

  // matched item register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s1_adv) begin
      item_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid) begin
      item <= item_next;
    end
  end

endmodule

`default_nettype wire

### rtl/ltmc_track.sv
// move state: elapsed time, marker count and end test
`timescale 1ns / 1ps
`default_nettype none

module ltmc_track (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  input  ltmc_pkg::item_t item,
  output logic            item_take,
  input  logic            job_ready,
  output logic            job_load,
  output ltmc_pkg::job_t  job
);
  import ltmc_pkg::*;

  logic [31:0] elapsed;
  logic [31:0] last_mark;
  logic [31:0] gap;
  logic [7:0]  marks;
  logic        moving;

  logic        run;
  logic        bad;
  logic [31:0] el_base;
  logic [31:0] lm_base;
  logic [31:0] gap_base;
  logic [7:0]  marks_base;
  logic [32:0] sum;
  logic        sat;
  logic [31:0] el_n;
  logic [31:0] gap_pre;
  logic        hit_limit;
  logic        mark_ok;
  logic [7:0]  marks_inc;
  logic [7:0]  marks_n;
  logic        re_mark;
  logic [31:0] lm_n;
  logic [31:0] gap_n;
  logic        finish;

  assign item_take = item_valid && job_ready;
  assign run       = item.start || moving;
  assign bad       = run && !item.dir_ok;
  assign job_load  = item_take && run;

  // a start clears the counters for this item
  assign el_base    = item.start ? 32'd0 : elapsed;
  assign lm_base    = item.start ? 32'd0 : last_mark;
  assign gap_base   = item.start ? 32'd0 : gap;
  assign marks_base = item.start ? 8'd0 : marks;

  // saturating elapsed time; gap tracks elapsed minus last mark time
  assign sum     = {1'b0, el_base} + 33'(item.inc);
  assign sat     = sum[32];
  assign el_n    = sat ? '1 : sum[31:0];
  assign gap_pre = sat ? ~lm_base : gap_base + 32'(item.inc);

  // end tests
  assign hit_limit = (item.limit != 16'd0) && (el_n >= 32'(item.limit));
  assign mark_ok   = (item.limit == 16'd0) && (gap_pre >= 32'(item.blank)) && item.marker;
  assign marks_inc = (marks_base != 8'hFF) ? marks_base + 8'd1 : marks_base;
  assign marks_n   = hit_limit ? item.target : (mark_ok ? marks_inc : marks_base);
  assign re_mark   = mark_ok && (marks_inc < item.target);
  assign lm_n      = re_mark ? el_n : lm_base;
  assign gap_n     = re_mark ? 32'd0 : gap_pre;
  assign finish    = marks_n >= item.target;

  // state update
  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed   <= 32'd0;
      last_mark <= 32'd0;
      gap       <= 32'd0;
      marks     <= 8'd0;
      moving    <= 1'b0;
    end else if (item_take) begin
      if (bad) begin
        moving <= 1'b0;
      end else if (run) begin
        elapsed   <= el_n;
        last_mark <= lm_n;
        gap       <= gap_n;
        marks     <= marks_n;
        moving    <= !finish;
      end
    end
  end

  // job for the serializer; a bad direction gives a single stopped done pulse
  always_comb begin
    if (bad) begin
      job.mask = '0;
      job.fb   = 1'b0;
      job.drv  = MOT_OFF;
      job.step = 16'd0;
      job.done = 1'b1;
    end else begin
      job.mask = item.mask;
      job.fb   = item.fb;
      job.drv  = item.drv;
      job.step = item.step;
      job.done = finish;
    end
  end

`ifndef SYNTHESIS
  // a finished move leaves the block idle
  a_done_stops: assert property (@(posedge clk) disable iff (rst)
    job_load && job.done |=> !moving)
    else $error("move still running after done job");

  // time since the last counted marker never exceeds elapsed time
  a_gap_bound: assert property (@(posedge clk) disable iff (rst)
    gap <= elapsed)
    else $error("marker gap exceeds elapsed time");
`endif

endmodule

`default_nettype wire

### rtl/ltmc_emit.sv
// pulse serializer and output register
`timescale 1ns / 1ps
`default_nettype none

module ltmc_emit (
  input  logic                clk,
  input  logic                rst,
  input  logic                job_load,
  input  ltmc_pkg::job_t      job_in,
  output logic                job_ready,
  output logic                out_valid,
  input  logic                out_stall,
  output ltmc_pkg::out_beat_t out_data
);
  import ltmc_pkg::*;

  logic                 job_valid;
  job_t                 job;
  logic [NUM_RULES-1:0] onehot;
  logic [NUM_RULES-1:0] rest;
  logic                 pick_last;
  logic                 out_load;
  out_beat_t            pulse;

  // lowest pending rule goes out first
  assign onehot    = job.mask & (~job.mask + 1'b1);
  assign rest      = job.mask & ~onehot;
  assign pick_last = (rest == '0);
  assign out_load  = job_valid && (!out_valid || !out_stall);
  assign job_ready = !job_valid || (out_load && pick_last);

  // pulse fields
  always_comb begin
    pulse.side_a_cmd = MOT_OFF;
    pulse.side_b_cmd = MOT_OFF;
    for (int i = 0; i < NUM_RULES; i++) begin
      if (onehot[i]) begin
        pulse.side_a_cmd = pulse.side_a_cmd | (job.fb ? FB_A[i] : LR_A[i]);
        pulse.side_b_cmd = pulse.side_b_cmd | (job.fb ? FB_B[i] : LR_B[i]);
      end
    end
    pulse.drive_cmd = (pick_last && job.done) ? MOT_OFF : job.drv;
    pulse.pulse_ms  = job.step;
    pulse.done_res  = pick_last && job.done;
    pulse.last      = pick_last;
  end

  // job register
  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (job_load) begin
      job_valid <= 1'b1;
    end else if (out_load && pick_last) begin
      job_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (job_load) begin
      job <= job_in;
    end else if (out_load) begin
      job.mask <= rest;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= pulse;
    end
  end

`ifndef SYNTHESIS
  // a job with pulses left stays loaded
  a_job_holds: assert property (@(posedge clk) disable iff (rst)
    out_load && !pick_last |=> job_valid)
    else $error("job dropped with pulses pending");

  // the final pulse of a finishing job reports done with the drive stopped
  a_done_beat: assert property (@(posedge clk) disable iff (rst)
    out_load && pick_last && job.done |=>
      out_valid && out_data.done_res && out_data.last && (out_data.drive_cmd == MOT_OFF))
    else $error("done beat malformed");
`endif

endmodule

`default_nettype wire

### rtl/line_tracking_move_controller_top.sv
// top level of the line tracking move controller
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake           beat
// in        input      in_valid/in_stall   start_req, sensors
// out       output     out_valid/out_stall side_a_cmd, side_b_cmd, drive_cmd,
//                                          pulse_ms, done_res, last
// cfg       input      cfg_we              cfg_index, cfg_data
//
// Each snapshot taken on a start or in a move gives one to four output beats,
// one beat per cycle unless out_stall holds them; the pulse serializer sets the rate.
// After the item is taken, its first beat passes the job register, then the output register.
// Reset is synchronous; there is no clearing pass.
// out_stall holds the output register and backs up through the job,
// match and input registers to in_stall.

module line_tracking_move_controller_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  ltmc_pkg::in_beat_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output ltmc_pkg::out_beat_t                 out_data,
  input  logic                                cfg_we,
  input  logic [ltmc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ltmc_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import ltmc_pkg::*;

  cfg_t  cfg_regs;
  logic  item_valid;
  item_t item;
  logic  item_take;
  logic  job_ready;
  logic  job_load;
  job_t  job;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.direction <= RST_DIRECTION;
      cfg_regs.count_arg <= RST_COUNT_ARG;
      cfg_regs.time_arg  <= RST_TIME_ARG;
      cfg_regs.blank_ms  <= RST_BLANK_MS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DIRECTION: cfg_regs.direction <= cfg_data[2:0];
        CFG_COUNT_ARG: cfg_regs.count_arg <= cfg_data[8:0];
        CFG_TIME_ARG:  cfg_regs.time_arg  <= cfg_data;
        CFG_BLANK_MS:  cfg_regs.blank_ms  <= cfg_data;
      endcase
    end
  end

  // input register and rule matching
  ltmc_match u_match (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .cfg        (cfg_regs),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  // move state and end test
  ltmc_track u_track (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take),
    .job_ready  (job_ready),
    .job_load   (job_load),
    .job        (job)
  );

  // pulse serializer
  ltmc_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .job_load  (job_load),
    .job_in    (job),
    .job_ready (job_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
